// ===== rtl/core/qsel_pkg.sv =====
// ----------------------------------------------------------------------------
// qsel_pkg
// Shared widths and codes for the quickselect k-th smallest block.
// ----------------------------------------------------------------------------
package qsel_pkg;

  // Item field widths
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int RANK_W = 9;
  localparam int STAT_W = 2;

  // Default number of stored values
  localparam int STORE_DEPTH_DEF = 256;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANK = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

// ===== rtl/core/qsel_ram.sv =====
// ----------------------------------------------------------------------------
// qsel_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address collision).
// ----------------------------------------------------------------------------
module qsel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/kth_smallest_quickselect_top.sv =====
// ----------------------------------------------------------------------------
// kth_smallest_quickselect_top
// Store of signed 32-bit values with clear, append and k-th smallest query.
// The query runs quickselect in place in the store RAM (last element pivot).
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  input     in_operation, in_value, in_rank         start && !busy
//  result    out_selected, out_status                out_valid, one cycle
//
//  Clear, append and a rejected query: result one cycle after the item is
//  taken; busy stays low, so items may follow every cycle.
//  Query: busy from the cycle after acceptance until the result. A pass over
//  a range loads its last value as pivot, scans i up and j down, swaps
//  pairs and ends with the pivot swap; the single RAM read port serializes
//  the reads. The run time is data dependent.
//  Reset: synchronous; store count and range clear, no RAM clearing pass.
//  The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module kth_smallest_quickselect_top #(
  parameter int STORE_DEPTH = qsel_pkg::STORE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [qsel_pkg::OP_W-1:0]           in_operation,
  input  logic signed [qsel_pkg::DATA_W-1:0]  in_value,
  input  logic [qsel_pkg::RANK_W-1:0]         in_rank,
  output logic                                out_valid,
  output logic signed [qsel_pkg::DATA_W-1:0]  out_selected,
  output logic [qsel_pkg::STAT_W-1:0]         out_status
);

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > qsel_pkg::RANK_W) ? CNT_W : qsel_pkg::RANK_W;
  localparam int DW    = qsel_pkg::DATA_W;

  // state codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PIV    = 3'd1;
  localparam logic [2:0] S_SCAN_I = 3'd2;
  localparam logic [2:0] S_SCAN_J = 3'd3;
  localparam logic [2:0] S_SWAP2  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;
  localparam logic [2:0] S_FIN2   = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        lo_r, lo_nxt;
  logic [IDX_W-1:0]        hi_r, hi_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt;
  logic [IDX_W-1:0]        j_r, j_nxt;
  logic [qsel_pkg::RANK_W-1:0] k_r, k_nxt;
  logic signed [DW-1:0]    piv_r, piv_nxt;
  logic signed [DW-1:0]    vi_r, vi_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [DW-1:0]    out_sel_r, out_sel_nxt;
  logic [qsel_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;

  // RAM port signals
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic signed [DW-1:0]    ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic signed [DW-1:0]    ram_rdata;

  // helper values
  logic [CNT_W-1:0]        cnt_m1;
  logic [CMP_W-1:0]        rank_ext;
  logic [CMP_W-1:0]        count_ext;
  logic [CMP_W-1:0]        k_ext;
  logic [CMP_W-1:0]        pos1;
  logic                    rd_less;
  logic                    store_full;

  assign cnt_m1     = count_r - CNT_W'(1);
  assign rank_ext   = CMP_W'(in_rank);
  assign count_ext  = CMP_W'(count_r);
  assign k_ext      = CMP_W'(k_r);
  assign pos1       = CMP_W'(i_r) + CMP_W'(1);
  assign rd_less    = (ram_rdata < piv_r);
  assign store_full = (count_r == CNT_W'(STORE_DEPTH));

  qsel_ram #(
    .WIDTH (DW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer: item decode and partition passes
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    piv_nxt       = piv_r;
    vi_nxt        = vi_r;
    out_valid_nxt = 1'b0;
    out_sel_nxt   = out_sel_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;
    ram_waddr     = i_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = i_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_sel_nxt  = '0;
          out_stat_nxt = qsel_pkg::ST_OK;
          unique case (in_operation)
            qsel_pkg::OP_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            qsel_pkg::OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (store_full) begin
                out_stat_nxt = qsel_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[IDX_W-1:0];
                ram_wdata = in_value;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            qsel_pkg::OP_QUERY: begin
              if (in_rank == '0 || rank_ext > count_ext) begin
                out_valid_nxt = 1'b1;
                out_stat_nxt  = qsel_pkg::ST_RANK;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = cnt_m1[IDX_W-1:0];
                ram_raddr = cnt_m1[IDX_W-1:0];
                k_nxt     = in_rank;
                state_nxt = S_PIV;
              end
            end
            default: begin
              // unused code: no state change
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // pivot arrives; start left scan
      S_PIV: begin
        piv_nxt   = ram_rdata;
        i_nxt     = lo_r;
        j_nxt     = hi_r;
        ram_raddr = lo_r;
        state_nxt = S_SCAN_I;
      end

      // advance i past elements below the pivot
      S_SCAN_I: begin
        if (i_r == j_r) begin
          ram_raddr = i_r;
          state_nxt = S_FIN;
        end else if (rd_less) begin
          i_nxt     = i_r + IDX_W'(1);
          ram_raddr = i_r + IDX_W'(1);
        end else begin
          vi_nxt    = ram_rdata;
          ram_raddr = j_r;
          state_nxt = S_SCAN_J;
        end
      end

      // retreat j past elements not below the pivot
      S_SCAN_J: begin
        if (i_r == j_r) begin
          ram_raddr = i_r;
          state_nxt = S_FIN;
        end else if (!rd_less) begin
          j_nxt     = j_r - IDX_W'(1);
          ram_raddr = j_r - IDX_W'(1);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = i_r;
          ram_wdata = ram_rdata;
          state_nxt = S_SWAP2;
        end
      end

      // second half of swap; new store[i] is below pivot, so step i
      S_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = vi_r;
        i_nxt     = i_r + IDX_W'(1);
        ram_raddr = i_r + IDX_W'(1);
        state_nxt = S_SCAN_I;
      end

      // final pivot swap, first half: store[hi] <- store[i]
      S_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = ram_rdata;
        state_nxt = S_FIN2;
      end

      // store[i] <- pivot, then narrow the range or finish
      S_FIN2: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = piv_r;
        if (pos1 == k_ext) begin
          out_valid_nxt = 1'b1;
          out_sel_nxt   = piv_r;
          out_stat_nxt  = qsel_pkg::ST_OK;
          state_nxt     = S_IDLE;
        end else if (pos1 > k_ext) begin
          hi_nxt    = i_r - IDX_W'(1);
          ram_raddr = i_r - IDX_W'(1);
          state_nxt = S_PIV;
        end else begin
          lo_nxt    = i_r + IDX_W'(1);
          ram_raddr = hi_r;
          state_nxt = S_PIV;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    piv_r      <= piv_nxt;
    vi_r       <= vi_nxt;
    out_sel_r  <= out_sel_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_selected = out_sel_r;
  assign out_status   = out_stat_r;

endmodule

// ===== rtl/core/qsel_checker.sv =====
// ----------------------------------------------------------------------------
// qsel_checker
// Port-level checks for the quickselect block, bound to the top level.
// ----------------------------------------------------------------------------
module qsel_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [qsel_pkg::OP_W-1:0]           in_operation,
  input logic [qsel_pkg::RANK_W-1:0]         in_rank,
  input logic                                out_valid,
  input logic signed [qsel_pkg::DATA_W-1:0]  out_selected,
  input logic [qsel_pkg::STAT_W-1:0]         out_status
);

  // non-query items answer in the next cycle
  a_fast_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation != qsel_pkg::OP_QUERY |=> out_valid)
    else $error("non-query item not answered in one cycle");

  // rank zero is rejected at once
  a_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == qsel_pkg::OP_QUERY && in_rank == '0
    |=> out_valid && out_status == qsel_pkg::ST_RANK)
    else $error("rank zero not flagged");

  // error results carry zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != qsel_pkg::ST_OK |-> out_selected == '0)
    else $error("error result with nonzero value");

  // a result leaves the block idle
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while presenting a result");

endmodule

bind kth_smallest_quickselect_top qsel_checker u_qsel_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_operation (in_operation),
  .in_rank      (in_rank),
  .out_valid    (out_valid),
  .out_selected (out_selected),
  .out_status   (out_status)
);
